>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/slvk_pkg.sv
package slvk_pkg;

    localparam int WINDOW_DEF  = 8;
    localparam int SAMPLE_W    = 16;
    localparam int ENTRY_W     = 15;
    localparam int LVL_W       = 6;
    localparam int STEP_W      = 4;
    localparam int MEAN_W      = 12;
    localparam int PROD_W      = MEAN_W + LVL_W;
    localparam int RAW_MAX     = 4095;
    localparam int ROUND_HALF  = RAW_MAX / 2;
    localparam int MAX_RESULTS = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [LVL_W-1:0]  level_count;
        logic [LVL_W-1:0]  deadband;
        logic [STEP_W-1:0] max_steps;
    } cfg_t;

    typedef struct packed {
        logic              up;
        logic [STEP_W-1:0] steps;
    } burst_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SUM,
        F_DIV,
        F_MUL,
        F_LVL,
        F_DEC
    } front_state_t;

endpackage

>>> rtl/slider_to_volume_step_keys_top.sv
// Channel   Dir  Words                  Fields (low bit up)
// s_axis    in   one ADC sample         tdata: sample[15:0]; tuser: read_ok, asleep
// m_axis    out  one volume key         tdata: volume_up; tlast: last_in_run
// apb       in   register access        0x0 level_count, 0x4 deadband, 0x8 max_steps
//
// A sample that is asleep or read-failed is only accepted; before the window first
// fills a sample is accepted and summed; otherwise its steps are accept, running sum,
// mean by reciprocal multiply, level scaling, rounding and key decision.
// Key words leave a two-entry burst queue at one per cycle while m_tready is high.
// Reset is asynchronous; the window store is not cleared, no clearing pass.
// With the output stalled the queue fills, the front holds its decision and stops
// taking samples until a queue entry frees.
module slider_to_volume_step_keys_top
    import slvk_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[15:0]
    input  logic [1:0]  s_tuser,   // read_ok, asleep
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // volume_up, zero fill
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] REG_DEADBAND    = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS   = 2'd2;

    localparam logic [LVL_W-1:0]  LEVEL_COUNT_RST = LVL_W'(50);
    localparam logic [LVL_W-1:0]  DEADBAND_RST    = LVL_W'(1);
    localparam logic [STEP_W-1:0] MAX_STEPS_RST   = STEP_W'(3);

    cfg_t   cfg_reg, cfg_next;
    logic   wr_en;
    logic   q_full, q_push, q_empty, q_pop;
    burst_t q_data, q_head;
    logic   volume_up;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_LEVEL_COUNT: cfg_next.level_count = pwdata[LVL_W-1:0];
                REG_DEADBAND:    cfg_next.deadband    = pwdata[LVL_W-1:0];
                REG_MAX_STEPS:   cfg_next.max_steps   = pwdata[STEP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
        case (paddr[3:2])
            REG_LEVEL_COUNT: prdata = 32'(cfg_reg.level_count);
            REG_DEADBAND:    prdata = 32'(cfg_reg.deadband);
            REG_MAX_STEPS:   prdata = 32'(cfg_reg.max_steps);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_count <= LEVEL_COUNT_RST;
            cfg_reg.deadband    <= DEADBAND_RST;
            cfg_reg.max_steps   <= MAX_STEPS_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    slvk_front #(
        .WINDOW(WINDOW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sample  (s_tdata),
        .read_ok (s_tuser[0]),
        .asleep  (s_tuser[1]),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    slvk_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_data),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    slvk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .volume_up(volume_up),
        .last     (m_tlast)
    );

    assign m_tdata = {7'b0, volume_up};

endmodule

>>> rtl/slvk_div.sv
module slvk_div
    import slvk_pkg::*;
#(
    parameter int N_W     = 18,
    parameter int DIVISOR = 8
)
(
    input  logic           clk,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    output logic [N_W-1:0] quotient
);

    // floor(n / d) = (n * ceil(2^(N_W + clog2 d) / d)) >> (N_W + clog2 d) for n < 2^N_W
    localparam int     LOG_D = $clog2(DIVISOR);
    localparam int     SHIFT = N_W + LOG_D;
    localparam int     M_W   = N_W + 1;
    localparam int     P_W   = N_W + M_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);

    logic [M_W-1:0] recip;
    logic [P_W-1:0] prod;
    logic [N_W-1:0] quo_reg, quo_next;

    always_comb
    begin
        recip    = M_W'(RECIP);
        prod     = P_W'(dividend) * P_W'(recip);
        quo_next = start ? N_W'(prod[P_W-1:SHIFT]) : quo_reg;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

>>> rtl/slvk_fifo.sv
module slvk_fifo
    import slvk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output burst_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    burst_t           entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        full        = cnt_reg == CNT_W'(QUEUE_DEPTH);
        empty       = cnt_reg == '0;
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
        head = entries[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/slvk_front.sv
`include "assert_macros.svh"

module slvk_front
    import slvk_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                read_ok,
    input  logic                asleep,
    input  cfg_t                cfg,
    input  logic                q_full,
    output logic                q_push,
    output burst_t              q_data
);

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W = ENTRY_W + $clog2(WINDOW);

    front_state_t       state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               full_reg, full_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LVL_W-1:0]   stable_reg, stable_next;
    logic               known_reg, known_next;
    logic [ENTRY_W-1:0] clamp_reg, clamp_next;
    logic               sub_reg, sub_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [LVL_W-1:0]   target_reg, target_next;

    logic [ENTRY_W-1:0] window_mem [WINDOW];
    logic [ENTRY_W-1:0] old_reg;
    logic               mem_we;

    logic               div_start;
    logic [TOTAL_W-1:0] div_quo;

    logic               accept, take;
    logic [MEAN_W-1:0]  mean_clamp;
    logic [PROD_W-1:0]  rounded;
    logic [MEAN_W:0]    rem_est;
    logic [LVL_W:0]     target_wide;
    logic               dec_up;
    logic [LVL_W-1:0]   dec_mag;
    logic [STEP_W-1:0]  dec_cap, dec_steps;

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        full_next   = full_reg;
        total_next  = total_reg;
        stable_next = stable_reg;
        known_next  = known_reg;
        clamp_next  = clamp_reg;
        sub_next    = sub_reg;
        prod_next   = prod_reg;
        target_next = target_reg;
        div_start   = 1'b0;
        q_push      = 1'b0;

        s_tready    = state_reg == F_IDLE;
        accept      = s_tvalid && s_tready;
        take        = accept && read_ok && !asleep;
        mem_we      = take;

        mean_clamp  = (div_quo > TOTAL_W'(RAW_MAX)) ? MEAN_W'(RAW_MAX) : div_quo[MEAN_W-1:0];
        rounded     = prod_reg + PROD_W'(ROUND_HALF);
        rem_est     = {1'b0, rounded[MEAN_W-1:0]} + (MEAN_W + 1)'(rounded[PROD_W-1:MEAN_W]);
        target_wide = {1'b0, rounded[PROD_W-1:MEAN_W]}
                      + ((rem_est >= (MEAN_W + 1)'(RAW_MAX)) ? (LVL_W + 1)'(1) : '0);

        dec_up      = target_reg > stable_reg;
        dec_mag     = dec_up ? (target_reg - stable_reg) : (stable_reg - target_reg);
        dec_cap     = (cfg.max_steps > STEP_W'(MAX_RESULTS)) ? STEP_W'(MAX_RESULTS)
                                                             : cfg.max_steps;
        dec_steps   = (dec_mag < LVL_W'(dec_cap)) ? dec_mag[STEP_W-1:0] : dec_cap;
        q_data.up    = dec_up;
        q_data.steps = dec_steps;

        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    clamp_next = sample[SAMPLE_W-1] ? '0 : sample[ENTRY_W-1:0];
                    sub_next   = full_reg;
                    if (slot_reg == SLOT_W'(WINDOW - 1))
                    begin
                        slot_next = '0;
                        full_next = 1'b1;
                    end
                    else
                        slot_next = slot_reg + SLOT_W'(1);
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                total_next = total_reg - (sub_reg ? TOTAL_W'(old_reg) : '0)
                             + TOTAL_W'(clamp_reg);
                if (!known_reg && !full_reg)
                    state_next = F_IDLE;
                else
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                div_start  = 1'b1;
                state_next = F_MUL;
            end
            F_MUL:
            begin
                prod_next  = PROD_W'(mean_clamp) * PROD_W'(cfg.level_count);
                state_next = F_LVL;
            end
            F_LVL:
            begin
                target_next = target_wide[LVL_W-1:0];
                state_next  = F_DEC;
            end
            F_DEC:
            begin
                if (!known_reg)
                begin
                    stable_next = target_reg;
                    known_next  = 1'b1;
                    state_next  = F_IDLE;
                end
                else if (dec_mag <= cfg.deadband || dec_steps == '0)
                    state_next = F_IDLE;
                else if (!q_full)
                begin
                    q_push      = 1'b1;
                    stable_next = dec_up ? stable_reg + LVL_W'(dec_steps)
                                         : stable_reg - LVL_W'(dec_steps);
                    state_next  = F_IDLE;
                end
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            slot_reg   <= '0;
            full_reg   <= 1'b0;
            total_reg  <= '0;
            stable_reg <= '0;
            known_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            full_reg   <= full_next;
            total_reg  <= total_next;
            stable_reg <= stable_next;
            known_reg  <= known_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clamp_reg  <= clamp_next;
        sub_reg    <= sub_next;
        prod_reg   <= prod_next;
        target_reg <= target_next;
    end

    // read-before-write: old_reg holds the entry being replaced
    always_ff @(posedge clk)
    begin
        old_reg <= window_mem[slot_reg];
        if (mem_we)
            window_mem[slot_reg] <= sample[SAMPLE_W-1] ? '0 : sample[ENTRY_W-1:0];
    end

    // mean is only formed once the window is full, so the divisor is always WINDOW
    slvk_div #(
        .N_W    (TOTAL_W),
        .DIVISOR(WINDOW)
    ) u_div (
        .clk     (clk),
        .start   (div_start),
        .dividend(total_reg),
        .quotient(div_quo)
    );

    `ASSERT_NXT(a_take_to_sum, clk, rst_n, take, state_reg == F_SUM)
    `ASSERT_IMP(a_push_steps, clk, rst_n, q_push, q_data.steps != '0 && q_data.steps <= 4'd8)
    `ASSERT_NXT(a_known_sticks, clk, rst_n, known_reg, known_reg)

endmodule

>>> rtl/slvk_back.sv
`include "assert_macros.svh"

module slvk_back
    import slvk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_empty,
    input  burst_t q_head,
    output logic   q_pop,
    output logic   m_tvalid,
    input  logic   m_tready,
    output logic   volume_up,
    output logic   last
);

    logic              valid_reg, valid_next;
    logic              up_out_reg, up_out_next;
    logic              last_reg, last_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic              up_reg, up_next;
    logic              advance;

    always_comb
    begin
        valid_next  = valid_reg;
        up_out_next = up_out_reg;
        last_next   = last_reg;
        rem_next    = rem_reg;
        up_next     = up_reg;
        q_pop       = 1'b0;
        advance     = !valid_reg || m_tready;
        if (advance)
        begin
            if (rem_reg != '0)
            begin
                valid_next  = 1'b1;
                up_out_next = up_reg;
                last_next   = rem_reg == STEP_W'(1);
                rem_next    = rem_reg - STEP_W'(1);
            end
            else if (!q_empty)
            begin
                q_pop       = 1'b1;
                valid_next  = 1'b1;
                up_out_next = q_head.up;
                up_next     = q_head.up;
                last_next   = q_head.steps == STEP_W'(1);
                rem_next    = q_head.steps - STEP_W'(1);
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_out_reg <= up_out_next;
        last_reg   <= last_next;
        up_reg     <= up_next;
    end

    assign m_tvalid  = valid_reg;
    assign volume_up = up_out_reg;
    assign last      = last_reg;

    `ASSERT_IMP(a_burst_open, clk, rst_n, rem_reg != '0, valid_reg && !last_reg)

endmodule

>>> verif/tb_slider_to_volume_step_keys_top.sv
module tb_slider_to_volume_step_keys_top;
    import slvk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN            = WINDOW_DEF;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_SAMPLES  = 27;

    localparam logic [3:0] REG_LEVEL_COUNT = 4'h0;
    localparam logic [3:0] REG_DEADBAND    = 4'h4;
    localparam logic [3:0] REG_MAX_STEPS   = 4'h8;
    localparam logic [3:0] REG_SPARE       = 4'hC;

    typedef struct {
        logic [15:0] sample;
        logic        read_ok;
        logic        asleep;
    } adc_word_t;

    typedef struct {
        logic up;
        logic last;
    } key_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adc_word_t sample_queue[$];
    key_word_t expected_keys[$];
    int        err_cnt = 0;
    int        idle_cycles = 0;
    logic      s_taken = 1'b0;

    // mirror of the block's registers and averaging state
    logic [LVL_W-1:0]  lvl_cnt = 6'd50;
    logic [LVL_W-1:0]  dband = 6'd1;
    logic [STEP_W-1:0] max_keys = 4'd3;
    logic [14:0]       win_store [WIN];
    int unsigned       wr_slot = 0;
    bit                win_full = 0;
    int unsigned       win_total = 0;
    int                tracked_level = 0;
    bit                level_known = 0;

    slider_to_volume_step_keys_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic step_slider(input adc_word_t w);
        int unsigned clamped;
        int unsigned cnt;
        int unsigned mean;
        int          target;
        int          diff;
        int          mag;
        int          cap;
        int          steps;
        key_word_t   k;
        if (w.asleep || !w.read_ok)
            return;
        clamped = w.sample[15] ? 0 : w.sample[14:0];
        if (win_full)
            win_total -= win_store[wr_slot];
        win_store[wr_slot] = clamped[14:0];
        win_total += clamped;
        wr_slot = (wr_slot + 1) % WIN;
        if (wr_slot == 0)
            win_full = 1;
        cnt = win_full ? WIN : wr_slot;
        mean = win_total / cnt;
        if (mean > RAW_MAX)
            mean = RAW_MAX;
        target = int'((mean * lvl_cnt + ROUND_HALF) / RAW_MAX);
        if (!level_known)
        begin
            if (win_full)
            begin
                tracked_level = target;
                level_known = 1;
            end
            return;
        end
        diff = target - tracked_level;
        mag = diff < 0 ? -diff : diff;
        if (mag <= int'(dband))
            return;
        cap = int'(max_keys) > MAX_RESULTS ? MAX_RESULTS : int'(max_keys);
        steps = mag < cap ? mag : cap;
        for (int i = 0; i < steps; i++)
        begin
            k.up = diff > 0;
            k.last = (i == steps - 1);
            expected_keys.push_back(k);
        end
        tracked_level += (diff > 0) ? steps : -steps;
    endtask

    // sample and key word monitor, register mirror, watchdog
    always @(posedge clk)
    begin
        key_word_t k;
        adc_word_t w;
        bit        busy;
        busy = 0;
        s_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            w.sample = s_tdata;
            w.read_ok = s_tuser[0];
            w.asleep = s_tuser[1];
            step_slider(w);
            busy = 1;
        end
        if (m_tvalid && m_tready)
        begin
            busy = 1;
            if (expected_keys.size() == 0)
            begin
                $display("%0t: unexpected key word up=%0b last=%0b", $realtime,
                         m_tdata[0], m_tlast);
                err_cnt++;
            end
            else
            begin
                k = expected_keys.pop_front();
                if (m_tdata !== {7'd0, k.up} || m_tlast !== k.last)
                begin
                    $display("%0t: key mismatch: expected tdata=%02h last=%0b, got tdata=%02h last=%0b",
                             $realtime, {7'd0, k.up}, k.last, m_tdata, m_tlast);
                    err_cnt++;
                end
            end
        end
        if (psel && penable && pwrite && pready)
        begin
            busy = 1;
            case (paddr)
                REG_LEVEL_COUNT: lvl_cnt = pwdata[LVL_W-1:0];
                REG_DEADBAND:    dband = pwdata[LVL_W-1:0];
                REG_MAX_STEPS:   max_keys = pwdata[STEP_W-1:0];
                default:         ;
            endcase
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        static int gap = 0;
        static bit calm = 0;
        adc_word_t w;
        if (!(s_tvalid && !s_taken))
        begin
            if (gap > 0)
            begin
                gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_queue.size() > 0)
            begin
                w = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= w.sample;
                s_tuser <= {w.asleep, w.read_ok};
                if ($urandom_range(0, 29) == 0)
                    calm = !calm;
                gap = idle_len(calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // key word back-pressure
    always @(negedge clk)
    begin
        static int hold = 0;
        static bit calm = 0;
        if (hold > 0)
        begin
            hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            hold = ($urandom_range(0, 2) == 0) ? idle_len(calm) : 0;
        end
    end

    task automatic add_sample(input logic [15:0] smp, input logic ok, input logic slp);
        adc_word_t w;
        w.sample = smp;
        w.read_ok = ok;
        w.asleep = slp;
        sample_queue.push_back(w);
    endtask

    // block idle: nothing queued, nothing owed, and time for a silent sample to finish
    task automatic wait_settled();
        do
            @(posedge clk);
        while (sample_queue.size() != 0 || s_tvalid || expected_keys.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_random_samples(input int n, inout int slider);
        int         valid;
        int         r;
        logic [15:0] smp;
        logic [15:0] extremes [6];
        extremes = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd4095, 16'd4096};
        valid = 0;
        while (valid < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                case ($urandom_range(0, 2))
                    0:       add_sample(16'($urandom), 1'b1, 1'b1);
                    1:       add_sample(16'($urandom), 1'b0, 1'b0);
                    default: add_sample(16'($urandom), 1'b0, 1'b1);
                endcase
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    slider += $urandom_range(0, 1600) - 800;
                    if (slider < 0)
                        slider = 0;
                    if (slider > RAW_MAX)
                        slider = RAW_MAX;
                    smp = 16'(slider);
                end
                else if (r < 65)
                begin
                    slider = $urandom_range(0, RAW_MAX);
                    smp = 16'(slider);
                end
                else if (r < 75)
                    smp = 16'($urandom);
                else if (r < 85)
                    smp = extremes[$urandom_range(0, 5)];
                else
                    smp = 16'(slider);
                add_sample(smp, 1'b1, 1'b0);
                valid++;
            end
        end
    endtask

    initial
    begin
        int lc_set [PHASES];
        int db_set [PHASES];
        int ms_set [PHASES];
        int slider;
        lc_set = '{63, 1, 0, 50, 20, 63, 10, 33};
        db_set = '{0, 0, 0, 63, 2, 0, 1, 5};
        ms_set = '{8, 1, 15, 3, 0, 9, 4, 8};
        slider = 2048;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: ignored words, negative clamp, window fill, clamp of the mean
        add_sample(16'h7FFF, 1'b1, 1'b1);
        add_sample(16'h8000, 1'b0, 1'b0);
        add_sample(16'h7FFF, 1'b0, 1'b1);
        add_sample(16'h8000, 1'b1, 1'b0);
        add_sample(16'hFFFF, 1'b1, 1'b0);
        repeat (6) add_sample(16'h0000, 1'b1, 1'b0);
        add_sample(16'h0001, 1'b1, 1'b0);
        add_sample(16'h7FFF, 1'b1, 1'b0);
        add_sample(16'h7FFF, 1'b1, 1'b0);
        add_sample(16'h7FFF, 1'b0, 1'b1);
        add_sample(16'd4095, 1'b1, 1'b0);
        add_sample(16'd4096, 1'b1, 1'b0);
        add_sample(16'h7FFF, 1'b1, 1'b0);
        repeat (4) add_sample(16'h8000, 1'b1, 1'b0);
        add_sample(16'h0000, 1'b1, 1'b0);
        add_sample(16'd2048, 1'b1, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_settled();
            // upper bits set to check the register masking
            apb_write(REG_LEVEL_COUNT, 32'hA5A5_A5C0 | 32'(lc_set[p]));
            apb_write(REG_DEADBAND, 32'h5A5A_5AC0 | 32'(db_set[p]));
            apb_write(REG_MAX_STEPS, 32'hFFFF_FFF0 | 32'(ms_set[p]));
            if (p == 0)
                apb_write(REG_SPARE, 32'hFFFF_FFFF);
            add_random_samples(PHASE_SAMPLES, slider);
        end

        wait_settled();
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
